// ===== rtl/core/tme_pkg.sv =====
// tme_pkg: shared types and field widths of the tape machine executor
package tme_pkg;

	localparam int OP_W       = 3;
	localparam int AMOUNT_W   = 16;
	localparam int TARGET_W   = 16;
	localparam int CELL_W     = 8;
	localparam int PC_OUT_W   = 16;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 32;
	localparam int RESULT_W   = PC_OUT_W + 1 + CELL_W + 1;

	typedef enum logic [OP_W-1:0] {
		OP_MOVE,
		OP_ADD,
		OP_READ,
		OP_WRITE,
		OP_LOOP_START,
		OP_LOOP_END,
		OP_CLEAR,
		OP_HALT
	} op_t;

	// result word, lowest field last
	typedef struct packed {
		logic                halted;
		logic [CELL_W-1:0]   out_byte;
		logic                out_valid;
		logic [PC_OUT_W-1:0] next_pc;
	} result_t;

endpackage

// ===== rtl/core/tape_machine_executor_top.sv =====
// tape_machine_executor_top: pre-decoded tape machine core around one tape ram
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tuser: req_type; s_tdata: amount, cell_offset,
//                                   jump_target, input_byte
//  m_*      out  m_tvalid/m_tready  m_tdata: next_pc, out_valid, out_byte, halted
//
// one word per cycle sustained while m_tready holds; a word passes the stage 1,
// stage 2 and result registers. the tape ram read in s1 and its read-modify-write
// in s2 set this pace; a write still pending behind a read of the same cell is
// forwarded. after reset a clearing pass zeroes the tape, one cell a cycle, and
// s_tready stays low until the pass has cleared the last cell
// a stall on the result side freezes the whole pipe, ram read data included
module tape_machine_executor_top #(
	parameter int TAPE_DEPTH    = 65536,
	parameter int PROGRAM_DEPTH = 65536
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// amount [15:0], cell_offset [31:16], jump_target [47:32], input_byte [55:48]
	input  logic [tme_pkg::IN_DATA_W-1:0]  s_tdata,
	// req_type [2:0]
	input  logic [tme_pkg::OP_W-1:0]       s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// next_pc [15:0], out_valid [16], out_byte [24:17], halted [25], zero above
	output logic [tme_pkg::OUT_DATA_W-1:0] m_tdata
);

	import tme_pkg::*;

	localparam int ADDR_W = $clog2(TAPE_DEPTH);
	localparam int PC_W   = $clog2(PROGRAM_DEPTH);
	localparam int PCX_W  = (PC_W > PC_OUT_W) ? PC_W : PC_OUT_W;

	localparam logic [ADDR_W:0]   TAPE_LIM = (ADDR_W + 1)'(TAPE_DEPTH);
	localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(TAPE_DEPTH - 1);
	localparam logic [PC_W:0]     PC_LIM   = (PC_W + 1)'(PROGRAM_DEPTH);

	// pipe control
	logic adv;
	logic clr_busy_q;
	logic [ADDR_W-1:0] clr_addr_q;

	// reduced steps straight off the input word
	logic [ADDR_W-1:0] amt_step;
	logic [ADDR_W-1:0] off_step;
	logic [PC_W-1:0]   tgt_step;

	// stage 1: pointer update and tape read issue
	logic              valid_s1;
	op_t               op_s1;
	logic [ADDR_W-1:0] amt_step_s1;
	logic [ADDR_W-1:0] off_step_s1;
	logic [PC_W-1:0]   target_s1;
	logic [CELL_W-1:0] amt_lo_s1;
	logic [CELL_W-1:0] byte_s1;

	// stage 2: cell read-modify-write and program counter
	logic              valid_s2;
	op_t               op_s2;
	logic              nop_s2;
	logic [ADDR_W-1:0] addr_s2;
	logic [PC_W-1:0]   target_s2;
	logic [CELL_W-1:0] amt_lo_s2;
	logic [CELL_W-1:0] byte_s2;
	logic              halted_s2;

	// architectural state
	logic [ADDR_W-1:0] ptr_q;
	logic [PC_W-1:0]   pc_q;
	logic              halt_q;

	// last tape write, for a read issued in the same cycle
	logic              fwd_v_q;
	logic [ADDR_W-1:0] fwd_addr_q;
	logic [CELL_W-1:0] fwd_data_q;

	// result register
	logic    m_tvalid_q;
	result_t result_q;

	// stage 1 combinational
	logic [ADDR_W:0]   ptr_sum;
	logic [ADDR_W-1:0] ptr_next;
	logic [ADDR_W:0]   cell_sum;
	logic [ADDR_W-1:0] cell_addr;
	logic [ADDR_W-1:0] rd_addr;

	// stage 2 combinational
	logic [CELL_W-1:0] ram_rdata;
	logic [CELL_W-1:0] cell_val;
	logic [PC_W:0]     pc_sum;
	logic [PC_W-1:0]   pc_plus;
	logic [PC_W:0]     tgt_sum;
	logic [PC_W-1:0]   tgt_plus;
	logic              wr_s2;
	logic [CELL_W-1:0] wdata_s2;
	logic [PC_W-1:0]   pc_new;
	logic              ov_s2;
	logic [CELL_W-1:0] ob_s2;
	logic [PCX_W-1:0]  pc_ext;
	result_t           result_d;

	// ram port
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [CELL_W-1:0] ram_wdata;

	// the whole pipe moves when the result register can take a word
	assign adv      = !m_tvalid_q || m_tready;
	assign s_tready = adv && !clr_busy_q;

	// wrap amounts and targets before they meet any state
	tme_reduce #(
		.DEPTH     (TAPE_DEPTH),
		.IN_W      (AMOUNT_W),
		.SIGNED_IN (1'b1)
	) u_amt_reduce (
		.value (s_tdata[AMOUNT_W-1:0]),
		.step  (amt_step)
	);

	tme_reduce #(
		.DEPTH     (TAPE_DEPTH),
		.IN_W      (AMOUNT_W),
		.SIGNED_IN (1'b1)
	) u_off_reduce (
		.value (s_tdata[2*AMOUNT_W-1:AMOUNT_W]),
		.step  (off_step)
	);

	tme_reduce #(
		.DEPTH     (PROGRAM_DEPTH),
		.IN_W      (TARGET_W),
		.SIGNED_IN (1'b0)
	) u_tgt_reduce (
		.value (s_tdata[2*AMOUNT_W+TARGET_W-1:2*AMOUNT_W]),
		.step  (tgt_step)
	);

	// tape clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == LAST_CELL) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_tvalid && s_tready;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1       <= op_t'(s_tuser);
			amt_step_s1 <= amt_step;
			off_step_s1 <= off_step;
			target_s1   <= tgt_step;
			amt_lo_s1   <= s_tdata[CELL_W-1:0];
			byte_s1     <= s_tdata[IN_DATA_W-1:IN_DATA_W-CELL_W];
		end
	end

	// pointer moves and addressed cell, both modulo the tape size
	always_comb begin
		ptr_sum   = {1'b0, ptr_q} + {1'b0, amt_step_s1};
		ptr_next  = (ptr_sum >= TAPE_LIM) ? ADDR_W'(ptr_sum - TAPE_LIM) : ptr_sum[ADDR_W-1:0];
		cell_sum  = {1'b0, ptr_q} + {1'b0, off_step_s1};
		cell_addr = (cell_sum >= TAPE_LIM) ? ADDR_W'(cell_sum - TAPE_LIM)
		                                   : cell_sum[ADDR_W-1:0];
		// loop start tests the cell under the pointer itself
		rd_addr   = (op_s1 == OP_LOOP_START) ? ptr_q : cell_addr;
	end

	// pointer and halt flag settle in stage 1 so the next word sees them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			halt_q <= 1'b0;
		end else if (adv && valid_s1 && !halt_q) begin
			if (op_s1 == OP_MOVE) begin
				ptr_q <= ptr_next;
			end
			if (op_s1 == OP_HALT) begin
				halt_q <= 1'b1;
			end
		end
	end

	// stage 2 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			op_s2     <= op_s1;
			nop_s2    <= halt_q;
			addr_s2   <= rd_addr;
			target_s2 <= target_s1;
			amt_lo_s2 <= amt_lo_s1;
			byte_s2   <= byte_s1;
			halted_s2 <= halt_q || (op_s1 == OP_HALT);
		end
	end

	tme_ram #(
		.WIDTH (CELL_W),
		.DEPTH (TAPE_DEPTH)
	) u_tape (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (adv && valid_s1),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// stage 2: cell value, new cell, next program counter
	always_comb begin
		cell_val = (fwd_v_q && (fwd_addr_q == addr_s2)) ? fwd_data_q : ram_rdata;
		pc_sum   = {1'b0, pc_q} + 1'b1;
		pc_plus  = (pc_sum == PC_LIM) ? '0 : pc_sum[PC_W-1:0];
		tgt_sum  = {1'b0, target_s2} + 1'b1;
		tgt_plus = (tgt_sum == PC_LIM) ? '0 : tgt_sum[PC_W-1:0];
		wr_s2    = 1'b0;
		wdata_s2 = '0;
		pc_new   = pc_plus;
		ov_s2    = 1'b0;
		ob_s2    = '0;
		case (op_s2)
			OP_MOVE: begin
				pc_new = pc_plus;
			end
			OP_ADD: begin
				wr_s2    = 1'b1;
				wdata_s2 = cell_val + amt_lo_s2;
			end
			OP_READ: begin
				wr_s2    = 1'b1;
				wdata_s2 = byte_s2;
			end
			OP_WRITE: begin
				ov_s2 = 1'b1;
				ob_s2 = cell_val;
			end
			OP_LOOP_START: begin
				pc_new = (cell_val == '0) ? tgt_plus : pc_plus;
			end
			OP_LOOP_END: begin
				pc_new = target_s2;
			end
			OP_CLEAR: begin
				wr_s2 = 1'b1;
			end
			OP_HALT: begin
				pc_new = pc_q;
			end
			default: begin
				pc_new = pc_q;
			end
		endcase
		// once halted a word leaves everything as it is
		if (nop_s2) begin
			wr_s2  = 1'b0;
			pc_new = pc_q;
			ov_s2  = 1'b0;
			ob_s2  = '0;
		end
		pc_ext             = PCX_W'(pc_new);
		result_d.next_pc   = pc_ext[PC_OUT_W-1:0];
		result_d.out_valid = ov_s2;
		result_d.out_byte  = ob_s2;
		result_d.halted    = halted_s2;
	end

	// the clearing pass owns the write port until it ends
	assign ram_we    = clr_busy_q || (adv && valid_s2 && wr_s2);
	assign ram_waddr = clr_busy_q ? clr_addr_q : addr_s2;
	assign ram_wdata = clr_busy_q ? '0 : wdata_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= '0;
			fwd_v_q <= 1'b0;
		end else if (adv) begin
			fwd_v_q <= valid_s2 && wr_s2;
			if (valid_s2) begin
				pc_q <= pc_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fwd_addr_q <= addr_s2;
			fwd_data_q <= wdata_s2;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			result_q <= result_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(OUT_DATA_W - RESULT_W)'(0), result_q};

endmodule

// ===== rtl/core/tme_ram.sv =====
// tme_ram: generic single-write, single-read ram with registered read data
module tme_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/tme_reduce.sv =====
// tme_reduce: reduces a signed or unsigned field to a step modulo a constant depth
module tme_reduce #(
	parameter int DEPTH     = 65536,
	parameter int IN_W      = 16,
	parameter bit SIGNED_IN = 1'b1
) (
	input  logic [IN_W-1:0]          value,
	output logic [$clog2(DEPTH)-1:0] step
);

	localparam int OUT_W = $clog2(DEPTH);
	localparam int STEPS = (IN_W + 1 > OUT_W) ? IN_W - OUT_W + 1 : 0;
	localparam int RW    = (OUT_W > IN_W) ? OUT_W : IN_W;

	logic            neg;
	logic [IN_W-1:0] mag;
	logic [IN_W-1:0] rem;
	logic [RW-1:0]   rem_x;

	// restoring reduction: one compare and subtract per quotient bit
	always_comb begin
		neg = SIGNED_IN && value[IN_W-1];
		mag = neg ? -value : value;
		rem = mag;
		for (int k = STEPS - 1; k >= 0; k--) begin
			if (64'(rem) >= (64'(DEPTH) << k)) begin
				rem = rem - IN_W'(64'(DEPTH) << k);
			end
		end
		rem_x = RW'(rem);
		if (neg && (rem != '0)) begin
			step = OUT_W'(RW'(DEPTH) - rem_x);
		end else begin
			step = OUT_W'(rem_x);
		end
	end

endmodule
